[src/dh_orientation_chain_unit_defines.svh]
// ----------------------------------------------------------------------------
// dh_orientation_chain_unit_defines
// Assertion macros shared by the orientation chain RTL.
// ----------------------------------------------------------------------------
`ifndef DH_ORIENTATION_CHAIN_UNIT_DEFINES_SVH
`define DH_ORIENTATION_CHAIN_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define DHOC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DHOC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/dhoc_pkg.sv]
// ----------------------------------------------------------------------------
// dhoc_pkg
// Types, constants and rounding helpers of the orientation chain.
// ----------------------------------------------------------------------------
`default_nettype none

package dhoc_pkg;

	localparam int NUM_LINKS = 6;
	localparam int CORDIC_STEPS = 16;
	localparam int MAT_N = 9;
	localparam int SC_LAT = CORDIC_STEPS + 2;
	localparam int PIPE_LAT = 1 + SC_LAT + 1 + 2 * NUM_LINKS;

	localparam logic signed [20:0] PI_Q16 = 21'sd205887;
	localparam logic signed [20:0] TWO_PI_Q16 = 21'sd411775;
	localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
	localparam logic signed [18:0] CORDIC_GAIN = 19'sd39797;

	localparam logic [1:0] REG_THETA_LO = 2'd0;
	localparam logic [1:0] REG_THETA_HI = 2'd1;
	localparam logic [1:0] REG_TWIST_LO = 2'd2;
	localparam logic [1:0] REG_TWIST_HI = 2'd3;

	typedef logic signed [15:0] q14_t;
	typedef logic signed [16:0] ang_t;

	typedef struct packed {
		logic signed [18:0] x;
		logic signed [18:0] y;
		logic signed [19:0] z;
		logic               neg;
	} cordic_t;

	function automatic logic signed [19:0] atan_q16(input logic [3:0] step);
		logic signed [19:0] a;
		unique case (step)
			4'd0:  a = 20'sd51472;
			4'd1:  a = 20'sd30386;
			4'd2:  a = 20'sd16055;
			4'd3:  a = 20'sd8150;
			4'd4:  a = 20'sd4091;
			4'd5:  a = 20'sd2047;
			4'd6:  a = 20'sd1024;
			4'd7:  a = 20'sd512;
			4'd8:  a = 20'sd256;
			4'd9:  a = 20'sd128;
			4'd10: a = 20'sd64;
			4'd11: a = 20'sd32;
			4'd12: a = 20'sd16;
			4'd13: a = 20'sd8;
			4'd14: a = 20'sd4;
			4'd15: a = 20'sd2;
			default: a = 20'sd0;
		endcase
		return a;
	endfunction

	function automatic q14_t sat_q14(input logic signed [33:0] v);
		q14_t r;
		if (v > 34'sd16384)
			r = 16'sd16384;
		else if (v < -34'sd16384)
			r = -16'sd16384;
		else
			r = v[15:0];
		return r;
	endfunction

	// Q2.28 to Q1.14, round half up, saturate
	function automatic q14_t round_q28(input logic signed [33:0] v);
		logic signed [33:0] t;
		t = (v + 34'sd8192) >>> 14;
		return sat_q14(t);
	endfunction

endpackage

`default_nettype wire

[src/dhoc_cordic_cell.sv]
// ----------------------------------------------------------------------------
// dhoc_cordic_cell
// One registered rotation-mode CORDIC iteration.
// ----------------------------------------------------------------------------
`default_nettype none

module dhoc_cordic_cell import dhoc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       en,
	input  wire logic [3:0] step,
	input  wire cordic_t    d,
	output cordic_t         q
);

	cordic_t            nxt;
	logic signed [18:0] xs;
	logic signed [18:0] ys;
	logic signed [19:0] at;

	always_comb begin
		xs = d.x >>> step;
		ys = d.y >>> step;
		at = atan_q16(step);
		nxt.neg = d.neg;
		if (!d.z[19]) begin
			nxt.x = d.x - ys;
			nxt.y = d.y + xs;
			nxt.z = d.z - at;
		end else begin
			nxt.x = d.x + ys;
			nxt.y = d.y - xs;
			nxt.z = d.z + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

`default_nettype wire

[src/dhoc_sincos.sv]
// ----------------------------------------------------------------------------
// dhoc_sincos
// Pipelined sine/cosine: range reduction, sixteen CORDIC cells, scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module dhoc_sincos import dhoc_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  wire ang_t angle,
	output q14_t      sin_q,
	output q14_t      cos_q
);

	logic signed [20:0] z0;
	logic signed [20:0] z1;
	logic signed [20:0] z2;
	logic               neg0;
	cordic_t            pre_s1;
	cordic_t            stg [CORDIC_STEPS+1];
	logic signed [19:0] vx;
	logic signed [19:0] vy;
	logic signed [19:0] tx;
	logic signed [19:0] ty;

	always_comb begin
		z0 = {angle[16], angle[16], angle[16], angle, 1'b0} <<< 2;
		if (z0 > PI_Q16)
			z1 = z0 - TWO_PI_Q16;
		else if (z0 < -PI_Q16)
			z1 = z0 + TWO_PI_Q16;
		else
			z1 = z0;
		neg0 = 1'b1;
		if (z1 > HALF_PI_Q16)
			z2 = z1 - PI_Q16;
		else if (z1 < -HALF_PI_Q16)
			z2 = z1 + PI_Q16;
		else begin
			z2 = z1;
			neg0 = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s1.x <= CORDIC_GAIN;
			pre_s1.y <= '0;
			pre_s1.z <= z2[19:0];
			pre_s1.neg <= neg0;
		end
	end

	assign stg[0] = pre_s1;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		dhoc_cordic_cell u_cell (
			.clk  (clk),
			.en   (en),
			.step (4'(i)),
			.d    (stg[i]),
			.q    (stg[i+1])
		);
	end

	always_comb begin
		vx = stg[CORDIC_STEPS].neg ? -20'(stg[CORDIC_STEPS].x) : 20'(stg[CORDIC_STEPS].x);
		vy = stg[CORDIC_STEPS].neg ? -20'(stg[CORDIC_STEPS].y) : 20'(stg[CORDIC_STEPS].y);
		tx = (vx + 20'sd2) >>> 2;
		ty = (vy + 20'sd2) >>> 2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= sat_q14(34'(tx));
			sin_q <= sat_q14(34'(ty));
		end
	end

endmodule

`default_nettype wire

[src/dhoc_mat_cell.sv]
// ----------------------------------------------------------------------------
// dhoc_mat_cell
// One link of the chain: 3x3 product m*l in two stages, rounded to Q1.14.
// ----------------------------------------------------------------------------
`default_nettype none

module dhoc_mat_cell import dhoc_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  wire q14_t m_in  [MAT_N],
	input  wire q14_t l_in  [MAT_N],
	output q14_t      m_out [MAT_N]
);

	logic signed [31:0] p_s1 [3*MAT_N];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						p_s1[i*9+j*3+k] <= m_in[i*3+k] * l_in[k*3+j];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < MAT_N; n++) begin
				m_out[n] <= round_q28(34'(p_s1[n*3]) + 34'(p_s1[n*3+1])
					+ 34'(p_s1[n*3+2]));
			end
		end
	end

endmodule

`default_nettype wire

[src/dh_orientation_chain_unit.sv]
// Six-link rotation chain: six Q3.13 angles in, a Q1.14 3x3 orientation out.
// One beat per cycle in steady state unless the output stalls. Stages: one
// angle-sum stage, 18 sine/cosine stages (twelve CORDIC pipelines in
// parallel), one link-matrix stage and two stages per link in the chain of
// matrix cells. The pipeline halts as a whole while an output beat waits.
// ----------------------------------------------------------------------------
// dh_orientation_chain_unit
// Pipelined Denavit-Hartenberg orientation chain with stream ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dh_orientation_chain_unit_defines.svh"

module dh_orientation_chain_unit import dhoc_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [63:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// arm_angle_first, arm_angle_second, arm_angle_third,
	// gimbal_angle_first, gimbal_angle_second, gimbal_angle_third
	input  wire logic [95:0]  s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// rot_r0c0 .. rot_r2c2, row-major
	output logic [143:0]      m_axis_tdata
);

	logic [63:0]         theta_lo_q;
	logic [31:0]         theta_hi_q;
	logic [63:0]         twist_lo_q;
	logic [31:0]         twist_hi_q;
	logic [PIPE_LAT-1:0] vld_q;
	logic                pipe_en;
	ang_t                theta_s0 [NUM_LINKS];
	ang_t                alpha_s0 [NUM_LINKS];
	q14_t                st [NUM_LINKS];
	q14_t                ct [NUM_LINKS];
	q14_t                sa [NUM_LINKS];
	q14_t                ca [NUM_LINKS];
	q14_t                lnk_s [NUM_LINKS][MAT_N];
	q14_t                mch [NUM_LINKS+1][MAT_N];
	q14_t                ident [MAT_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			theta_lo_q <= '0;
			theta_hi_q <= '0;
			twist_lo_q <= '0;
			twist_hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THETA_LO: theta_lo_q <= cfg_data;
				REG_THETA_HI: theta_hi_q <= cfg_data[31:0];
				REG_TWIST_LO: twist_lo_q <= cfg_data;
				REG_TWIST_HI: twist_hi_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign pipe_en = !vld_q[PIPE_LAT-1] || m_axis_tready;
	assign s_axis_tready = pipe_en;
	assign m_axis_tvalid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pipe_en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
		end
	end

	for (genvar k = 0; k < NUM_LINKS; k++) begin : g_link
		logic signed [15:0] in_ang;
		logic signed [15:0] off;
		logic signed [15:0] twa;
		ang_t               ang;
		logic signed [31:0] p_sc;
		logic signed [31:0] p_ss;
		logic signed [31:0] p_cc;
		logic signed [31:0] p_cs;
		q14_t               l_cell [MAT_N];

		assign in_ang = s_axis_tdata[16*k +: 16];
		if (k < 4) begin : g_lo
			assign off = theta_lo_q[16*k +: 16];
			assign twa = twist_lo_q[16*k +: 16];
		end else begin : g_hi
			assign off = theta_hi_q[16*(k-4) +: 16];
			assign twa = twist_hi_q[16*(k-4) +: 16];
		end

		// first angle of each group enters negated
		if (k == 0 || k == 3) begin : g_neg
			assign ang = -17'(in_ang);
		end else begin : g_pos
			assign ang = 17'(in_ang);
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				theta_s0[k] <= ang + 17'(off);
				alpha_s0[k] <= 17'(twa);
			end
		end

		dhoc_sincos u_sc_theta (
			.clk   (clk),
			.en    (pipe_en),
			.angle (theta_s0[k]),
			.sin_q (st[k]),
			.cos_q (ct[k])
		);

		dhoc_sincos u_sc_alpha (
			.clk   (clk),
			.en    (pipe_en),
			.angle (alpha_s0[k]),
			.sin_q (sa[k]),
			.cos_q (ca[k])
		);

		assign p_sc = st[k] * ca[k];
		assign p_ss = st[k] * sa[k];
		assign p_cc = ct[k] * ca[k];
		assign p_cs = ct[k] * sa[k];

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				lnk_s[k][0] <= ct[k];
				lnk_s[k][1] <= -round_q28(34'(p_sc));
				lnk_s[k][2] <= round_q28(34'(p_ss));
				lnk_s[k][3] <= st[k];
				lnk_s[k][4] <= round_q28(34'(p_cc));
				lnk_s[k][5] <= -round_q28(34'(p_cs));
				lnk_s[k][6] <= '0;
				lnk_s[k][7] <= sa[k];
				lnk_s[k][8] <= ca[k];
			end
		end

		if (k == 0) begin : g_nodly
			assign l_cell = lnk_s[k];
		end else begin : g_dly
			q14_t dl_q [2*k][MAT_N];
			always_ff @(posedge clk) begin
				if (pipe_en) begin
					dl_q[0] <= lnk_s[k];
					for (int d = 1; d < 2*k; d++) begin
						dl_q[d] <= dl_q[d-1];
					end
				end
			end
			assign l_cell = dl_q[2*k-1];
		end

		dhoc_mat_cell u_mat (
			.clk   (clk),
			.en    (pipe_en),
			.m_in  (mch[k]),
			.l_in  (l_cell),
			.m_out (mch[k+1])
		);
	end

	for (genvar n = 0; n < MAT_N; n++) begin : g_out
		assign ident[n] = (n == 0 || n == 4 || n == 8) ? 16'sd16384 : 16'sd0;
		assign m_axis_tdata[16*n +: 16] = mch[NUM_LINKS][n];
	end

	assign mch[0] = ident;

	`DHOC_ASSERT_IMP(a_stall_blocks_in, m_axis_tvalid && !m_axis_tready, !s_axis_tready,
		"input beat taken while output stalled")
	`DHOC_ASSERT_NXT(a_pipe_frozen, !pipe_en, $stable(vld_q),
		"pipeline moved during stall")
	`DHOC_ASSERT_IMP(a_entry0_range, m_axis_tvalid,
		($signed(m_axis_tdata[15:0]) <= 16'sd16384)
		&& ($signed(m_axis_tdata[15:0]) >= -16'sd16384),
		"orientation entry out of range")

endmodule

`default_nettype wire
